// ===== design/rpn_pkg.sv =====
package rpn_pkg;

  localparam int DEF_STACK_DEPTH = 16;
  localparam int DEF_FRAC_BITS   = 16;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BADNUM = 3'd1;
  localparam logic [2:0] ST_BADEXP = 3'd2;
  localparam logic [2:0] ST_UNDER  = 3'd3;
  localparam logic [2:0] ST_BADOP  = 3'd4;
  localparam logic [2:0] ST_OVER   = 3'd5;
  localparam logic [2:0] ST_SAT    = 3'd6;

  typedef enum logic [4:0] {
    C_NONE, C_CHAR, C_NOTE, C_RD_B, C_RD_A, C_ADD, C_SUB, C_MUL, C_MUL_RND,
    C_DIV_START, C_DIV_STEP, C_DIV_RES, C_WR_OP, C_CV_INIT, C_CV_UP, C_CV_POW,
    C_CV_DIV_START, C_CV_DIV_RES, C_CV_RES, C_PUSH, C_TOK_CLR, C_EMIT
  } dp_op_e;

  typedef enum logic [2:0] {OPK_ADD, OPK_SUB, OPK_MUL, OPK_DIV, OPK_BAD} opk_e;

  typedef struct packed {
    dp_op_e     op;
    logic [2:0] code;
  } cmd_t;

  typedef struct packed {
    logic is_op;
    logic num_bad;
    logic fatal;
    logic stk_lt2;
    logic stk_empty;
    logic mant_zero;
    logic e_neg;
    logic cv_cnt_zero;
    logic lim_huge;
    logic pw_gt;
    logic div_last;
    logic div_zero;
    logic out_free;
    opk_e opk;
  } sts_t;

endpackage

// ===== design/rpn_ctrl.sv =====
module rpn_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_token_last,
  input  logic          in_expr_last,
  output logic          in_stall,
  input  rpn_pkg::sts_t sts,
  output rpn_pkg::cmd_t cmd
);
  import rpn_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_FIN, S_OP_RDB, S_OP_RDA, S_OP_EXEC, S_MUL_RND, S_DIV_STEP, S_DIV_RES,
    S_OP_WR, S_CV_INIT, S_CV_UP, S_CV_POW, S_CV_DIV, S_CV_DSTEP, S_CV_DIVRES,
    S_CV_RES, S_PUSH, S_TOK_END, S_EXPR_CHK, S_EMIT
  } state_e;

  state_e state_r, state_nxt;
  logic   el_r, el_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    el_nxt    = el_r;
    cmd.op    = C_NONE;
    cmd.code  = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = C_CHAR;
          el_nxt = in_expr_last;
          if (in_token_last) state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.is_op) begin
          if (sts.fatal) begin
            state_nxt = S_TOK_END;
          end else if (sts.stk_lt2) begin
            cmd.op = C_NOTE; cmd.code = ST_UNDER; state_nxt = S_TOK_END;
          end else begin
            state_nxt = S_OP_RDB;
          end
        end else if (sts.num_bad) begin
          cmd.op = C_NOTE; cmd.code = ST_BADNUM; state_nxt = S_TOK_END;
        end else if (sts.fatal) begin
          state_nxt = S_TOK_END;
        end else if (sts.mant_zero) begin
          state_nxt = S_CV_RES;
        end else begin
          state_nxt = S_CV_INIT;
        end
      end
      S_OP_RDB: begin
        cmd.op = C_RD_B; state_nxt = S_OP_RDA;
      end
      S_OP_RDA: begin
        cmd.op = C_RD_A; state_nxt = S_OP_EXEC;
      end
      S_OP_EXEC: begin
        unique case (sts.opk)
          OPK_ADD: begin cmd.op = C_ADD; state_nxt = S_OP_WR; end
          OPK_SUB: begin cmd.op = C_SUB; state_nxt = S_OP_WR; end
          OPK_MUL: begin cmd.op = C_MUL; state_nxt = S_MUL_RND; end
          OPK_DIV: begin
            cmd.op = C_DIV_START;
            state_nxt = sts.div_zero ? S_OP_WR : S_DIV_STEP;
          end
          default: begin
            cmd.op = C_NOTE; cmd.code = ST_BADOP; state_nxt = S_TOK_END;
          end
        endcase
      end
      S_MUL_RND: begin
        cmd.op = C_MUL_RND; state_nxt = S_OP_WR;
      end
      S_DIV_STEP: begin
        cmd.op = C_DIV_STEP;
        if (sts.div_last) state_nxt = S_DIV_RES;
      end
      S_DIV_RES: begin
        cmd.op = C_DIV_RES; state_nxt = S_OP_WR;
      end
      S_OP_WR: begin
        cmd.op = C_WR_OP; state_nxt = S_TOK_END;
      end
      S_CV_INIT: begin
        cmd.op = C_CV_INIT;
        state_nxt = sts.e_neg ? S_CV_POW : S_CV_UP;
      end
      S_CV_UP: begin
        cmd.op = C_CV_UP;
        if (sts.lim_huge || sts.cv_cnt_zero) state_nxt = S_CV_RES;
      end
      S_CV_POW: begin
        cmd.op = C_CV_POW;
        if (sts.pw_gt) state_nxt = S_CV_RES;
        else if (sts.cv_cnt_zero) state_nxt = S_CV_DIV;
      end
      S_CV_DIV: begin
        cmd.op = C_CV_DIV_START; state_nxt = S_CV_DSTEP;
      end
      S_CV_DSTEP: begin
        cmd.op = C_DIV_STEP;
        if (sts.div_last) state_nxt = S_CV_DIVRES;
      end
      S_CV_DIVRES: begin
        cmd.op = C_CV_DIV_RES; state_nxt = S_CV_RES;
      end
      S_CV_RES: begin
        cmd.op = C_CV_RES; state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd.op = C_PUSH; state_nxt = S_TOK_END;
      end
      S_TOK_END: begin
        cmd.op = C_TOK_CLR;
        state_nxt = el_r ? S_EXPR_CHK : S_IDLE;
      end
      S_EXPR_CHK: begin
        if (!sts.fatal) begin
          if (sts.stk_empty) begin
            cmd.op = C_NOTE; cmd.code = ST_UNDER;
          end else begin
            cmd.op = C_RD_B;
          end
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op = C_EMIT; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      el_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      el_r    <= el_nxt;
    end
  end

endmodule

// ===== design/rpn_dp.sv =====
module rpn_dp #(
  parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH,
  parameter int FRAC_BITS   = rpn_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rpn_pkg::cmd_t      cmd,
  input  logic [7:0]         in_ch,
  output rpn_pkg::sts_t      sts,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_value,
  output logic [2:0]         out_status
);
  import rpn_pkg::*;

  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int CW    = $clog2(STACK_DEPTH + 1);
  localparam int LIM_W = 68 + FRAC_BITS;
  localparam int DCW   = $clog2(LIM_W + 1);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [59:0] MANT_LIMIT = 60'd100000000000000000;
  localparam logic [59:0] MANT_FULL  = 60'd999999999999999999;
  localparam logic [63:0] RND_HALF   = 64'((64'd1 << FRAC_BITS) >> 1);

  typedef enum logic [2:0] {
    PH_START, PH_SIGN, PH_ERR, PH_INT, PH_FRAC, PH_EXPSTART, PH_EXPSIGN, PH_EXPDIG
  } phase_e;

  function automatic logic [32:0] to_word(input logic neg, input logic [63:0] mag);
    logic [32:0] r;
    if (neg) begin
      if (mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, ~mag[31:0] + 32'd1};
    end else begin
      if (mag > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, mag[31:0]};
    end
    return r;
  endfunction

  function automatic logic [63:0] mag_of(input logic [LIM_W-1:0] x, input logic hg);
    logic [63:0] m;
    if (hg || (x[LIM_W-1:64] != '0)) m = '1;
    else m = {1'b0, x[63:1]} + 64'(x[0]);
    return m;
  endfunction

  function automatic logic [32:0] sum_sat(input logic [32:0] s);
    logic [32:0] r;
    if (s[32] != s[31]) r = {1'b1, s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    else r = {1'b0, s[31:0]};
    return r;
  endfunction

  logic [31:0]      stk_mem [STACK_DEPTH];
  logic [CW-1:0]    cnt_r;
  logic [2:0]       held_r;
  phase_e           ph_r, ph_nxt;
  logic [59:0]      mant_r, mant_nxt;
  logic [7:0]       fd_r, fd_nxt;
  logic [7:0]       ex_r, ex_nxt;
  logic             eneg_r, eneg_nxt;
  logic             vneg_r, vneg_nxt;
  logic [7:0]       first_r;
  logic [1:0]       len_r;
  logic             zlp_r, zlp_nxt;
  logic [31:0]      b_r, a_r, res_r;
  logic [63:0]      prod_r;
  logic [LIM_W-1:0] lim_r;
  logic [LIM_W+3:0] pw_r;
  logic             huge_r;
  logic [8:0]       cv_cnt_r;
  logic [LIM_W-1:0] dv_q_r;
  logic [LIM_W+4:0] dv_rem_r;
  logic [LIM_W+3:0] dv_d_r;
  logic [DCW-1:0]   dv_cnt_r;
  logic             out_valid_r;
  logic [31:0]      out_value_r;
  logic [2:0]       out_status_r;

  logic             ch_dig, f_dig, fatal;
  logic [59:0]      dval;
  logic             p_bad, p_badexp, p_note;
  logic [11:0]      ex_sum;
  logic signed [9:0] e_s;
  logic [31:0]      ma, mb;
  logic [63:0]      prod_c, mul_mag;
  logic [32:0]      add_w, sub_w, mul_w, div_w, cv_w;
  logic [LIM_W+4:0] rem_sh;
  logic             rem_ge;
  logic             fat_req, sat_req;
  logic [2:0]       fat_code;
  logic [AW-1:0]    idx_top, idx_next, idx_push;

  assign ch_dig  = (in_ch >= CH_0) && (in_ch <= CH_9);
  assign f_dig   = (first_r >= CH_0) && (first_r <= CH_9);
  assign dval    = 60'(in_ch - CH_0);
  assign fatal   = (held_r != ST_OK) && (held_r != ST_SAT);
  assign idx_top  = AW'(cnt_r - CW'(1));
  assign idx_next = AW'(cnt_r - CW'(2));
  assign idx_push = AW'(cnt_r);

  always_comb begin
    ph_nxt   = ph_r;
    mant_nxt = mant_r;
    fd_nxt   = fd_r;
    ex_nxt   = ex_r;
    eneg_nxt = eneg_r;
    vneg_nxt = vneg_r;
    zlp_nxt  = zlp_r;
    p_bad    = 1'b0;
    p_badexp = 1'b0;
    p_note   = 1'b0;
    ex_sum   = 12'({4'b0, ex_r} * 12'd10 + 12'(dval));
    unique case (ph_r)
      PH_START, PH_SIGN: begin
        if ((ph_r == PH_START) && (in_ch == CH_PLUS || in_ch == CH_MINUS)) begin
          vneg_nxt = (in_ch == CH_MINUS);
          ph_nxt   = PH_SIGN;
        end else if (in_ch == CH_0) begin
          zlp_nxt = 1'b1; ph_nxt = PH_INT;
        end else if (ch_dig) begin
          mant_nxt = dval; ph_nxt = PH_INT;
        end else if (in_ch == CH_DOT) begin
          ph_nxt = PH_FRAC;
        end else if (ph_r == PH_START && (in_ch == CH_LE || in_ch == CH_UE)) begin
          ph_nxt = PH_EXPSTART;
        end else if (ph_r == PH_START) begin
          ph_nxt = PH_ERR;
        end else begin
          p_bad = 1'b1;
        end
      end
      PH_INT: begin
        if (zlp_r) begin
          if (in_ch == CH_DOT) begin
            zlp_nxt = 1'b0; ph_nxt = PH_FRAC;
          end else begin
            p_bad = 1'b1;
          end
        end else if (ch_dig) begin
          mant_nxt = (mant_r >= MANT_LIMIT) ? MANT_FULL : 60'(mant_r * 60'd10 + dval);
        end else if (in_ch == CH_DOT) begin
          ph_nxt = PH_FRAC;
        end else if (in_ch == CH_LE || in_ch == CH_UE) begin
          ph_nxt = PH_EXPSTART;
        end else begin
          p_bad = 1'b1;
        end
      end
      PH_FRAC: begin
        if (ch_dig) begin
          if (mant_r < MANT_LIMIT && fd_r != 8'hFF) begin
            mant_nxt = 60'(mant_r * 60'd10 + dval);
            fd_nxt   = fd_r + 8'd1;
          end
        end else if (in_ch == CH_LE || in_ch == CH_UE) begin
          ph_nxt = PH_EXPSTART;
        end else begin
          p_bad = 1'b1;
        end
      end
      PH_EXPSTART, PH_EXPSIGN: begin
        if ((ph_r == PH_EXPSTART) && (in_ch == CH_PLUS || in_ch == CH_MINUS)) begin
          eneg_nxt = (in_ch == CH_MINUS);
          ph_nxt   = PH_EXPSIGN;
        end else if (in_ch == CH_0) begin
          zlp_nxt = 1'b1; ph_nxt = PH_EXPDIG;
        end else if (ch_dig) begin
          ex_nxt = 8'(dval); ph_nxt = PH_EXPDIG;
        end else begin
          p_bad = 1'b1;
        end
      end
      PH_EXPDIG: begin
        if (zlp_r) begin
          p_badexp = 1'b1; ph_nxt = PH_ERR;
        end else if (ch_dig) begin
          ex_nxt = (ex_sum > 12'd255) ? 8'hFF : ex_sum[7:0];
        end else begin
          p_bad = 1'b1;
        end
      end
      default: p_note = 1'b1;
    endcase
    if (p_bad) ph_nxt = PH_ERR;
  end

  assign e_s = (eneg_r ? -$signed({2'b0, ex_r}) : $signed({2'b0, ex_r}))
             - $signed({2'b0, fd_r});

  assign ma      = a_r[31] ? (~a_r + 32'd1) : a_r;
  assign mb      = b_r[31] ? (~b_r + 32'd1) : b_r;
  assign prod_c  = 64'(ma) * 64'(mb);
  assign mul_mag = (prod_r + RND_HALF) >> FRAC_BITS;
  assign add_w   = sum_sat({a_r[31], a_r} + {b_r[31], b_r});
  assign sub_w   = sum_sat({a_r[31], a_r} - {b_r[31], b_r});
  assign mul_w   = to_word(a_r[31] ^ b_r[31], mul_mag);
  assign div_w   = to_word(a_r[31] ^ b_r[31], mag_of(dv_q_r, 1'b0));
  assign cv_w    = to_word(vneg_r, mag_of(lim_r, huge_r));
  assign rem_sh  = {dv_rem_r[LIM_W+3:0], dv_q_r[LIM_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, dv_d_r};

  always_comb begin
    fat_req  = 1'b0;
    fat_code = ST_OK;
    sat_req  = 1'b0;
    unique case (cmd.op)
      C_CHAR: begin
        fat_req  = p_bad | p_badexp | p_note;
        fat_code = p_badexp ? ST_BADEXP : ST_BADNUM;
      end
      C_NOTE: begin fat_req = 1'b1; fat_code = cmd.code; end
      C_ADD:       sat_req = add_w[32];
      C_SUB:       sat_req = sub_w[32];
      C_MUL_RND:   sat_req = mul_w[32];
      C_DIV_START: sat_req = (b_r == 32'd0);
      C_DIV_RES:   sat_req = div_w[32];
      C_CV_RES:    sat_req = (mant_r != '0) & cv_w[32];
      C_PUSH: begin
        fat_req  = (cnt_r == CW'(STACK_DEPTH));
        fat_code = ST_OVER;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == C_WR_OP) stk_mem[idx_next] <= res_r;
    else if (cmd.op == C_PUSH && cnt_r != CW'(STACK_DEPTH)) stk_mem[idx_push] <= res_r;
    if (cmd.op == C_RD_B) b_r <= stk_mem[idx_top];
    if (cmd.op == C_RD_A) a_r <= stk_mem[idx_next];
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      C_ADD:     res_r <= add_w[31:0];
      C_SUB:     res_r <= sub_w[31:0];
      C_MUL:     prod_r <= prod_c;
      C_MUL_RND: res_r <= mul_w[31:0];
      C_DIV_START: begin
        if (b_r == 32'd0)
          res_r <= (ma == 32'd0) ? 32'd0 : (a_r[31] ? 32'h8000_0000 : 32'h7FFF_FFFF);
        dv_q_r   <= LIM_W'(ma) << (FRAC_BITS + 1);
        dv_d_r   <= (LIM_W+4)'(mb);
        dv_rem_r <= '0;
        dv_cnt_r <= DCW'(LIM_W);
      end
      C_DIV_STEP: begin
        dv_rem_r <= rem_ge ? (rem_sh - {1'b0, dv_d_r}) : rem_sh;
        dv_q_r   <= {dv_q_r[LIM_W-2:0], rem_ge};
        dv_cnt_r <= dv_cnt_r - DCW'(1);
      end
      C_DIV_RES: res_r <= div_w[31:0];
      C_CV_INIT: begin
        lim_r    <= LIM_W'(mant_r) << (FRAC_BITS + 1);
        pw_r     <= (LIM_W+4)'(1);
        huge_r   <= 1'b0;
        cv_cnt_r <= e_s[9] ? 9'(-e_s) : 9'(e_s);
      end
      C_CV_UP: begin
        if (lim_r[LIM_W-1:64] != '0) begin
          huge_r <= 1'b1;
        end else if (cv_cnt_r != 9'd0) begin
          lim_r    <= LIM_W'(lim_r * LIM_W'(10));
          cv_cnt_r <= cv_cnt_r - 9'd1;
        end
      end
      C_CV_POW: begin
        if ({4'b0, lim_r} < pw_r) begin
          lim_r <= '0;
        end else if (cv_cnt_r != 9'd0) begin
          pw_r     <= (LIM_W+4)'(pw_r * (LIM_W+4)'(10));
          cv_cnt_r <= cv_cnt_r - 9'd1;
        end
      end
      C_CV_DIV_START: begin
        dv_q_r   <= lim_r;
        dv_d_r   <= pw_r;
        dv_rem_r <= '0;
        dv_cnt_r <= DCW'(LIM_W);
      end
      C_CV_DIV_RES: lim_r <= dv_q_r;
      C_CV_RES: res_r <= (mant_r == '0) ? 32'd0 : cv_w[31:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      held_r      <= ST_OK;
      ph_r        <= PH_START;
      mant_r      <= '0;
      fd_r        <= '0;
      ex_r        <= '0;
      eneg_r      <= 1'b0;
      vneg_r      <= 1'b0;
      first_r     <= '0;
      len_r       <= '0;
      zlp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fat_req && (held_r == ST_OK || held_r == ST_SAT)) held_r <= fat_code;
      else if (sat_req && held_r == ST_OK) held_r <= ST_SAT;
      if (cmd.op == C_CHAR) begin
        ph_r   <= ph_nxt;
        mant_r <= mant_nxt;
        fd_r   <= fd_nxt;
        ex_r   <= ex_nxt;
        eneg_r <= eneg_nxt;
        vneg_r <= vneg_nxt;
        zlp_r  <= zlp_nxt;
        if (len_r == 2'd0) first_r <= in_ch;
        if (len_r != 2'd2) len_r <= len_r + 2'd1;
      end
      if (cmd.op == C_TOK_CLR) begin
        ph_r    <= PH_START;
        mant_r  <= '0;
        fd_r    <= '0;
        ex_r    <= '0;
        eneg_r  <= 1'b0;
        vneg_r  <= 1'b0;
        first_r <= '0;
        len_r   <= '0;
        zlp_r   <= 1'b0;
      end
      if (cmd.op == C_WR_OP) cnt_r <= cnt_r - CW'(1);
      if (cmd.op == C_PUSH && cnt_r != CW'(STACK_DEPTH)) cnt_r <= cnt_r + CW'(1);
      if (cmd.op == C_EMIT) begin
        out_valid_r  <= 1'b1;
        out_value_r  <= fatal ? 32'd0 : b_r;
        out_status_r <= held_r;
        cnt_r        <= '0;
        held_r       <= ST_OK;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.is_op       = (len_r == 2'd1) && !f_dig;
    sts.num_bad     = (ph_r == PH_ERR) || (ph_r == PH_SIGN) || (ph_r == PH_START);
    sts.fatal       = fatal;
    sts.stk_lt2     = (cnt_r < CW'(2));
    sts.stk_empty   = (cnt_r == '0);
    sts.mant_zero   = (mant_r == '0);
    sts.e_neg       = e_s[9];
    sts.cv_cnt_zero = (cv_cnt_r == 9'd0);
    sts.lim_huge    = (lim_r[LIM_W-1:64] != '0);
    sts.pw_gt       = ({4'b0, lim_r} < pw_r);
    sts.div_last    = (dv_cnt_r == DCW'(1));
    sts.div_zero    = (b_r == 32'd0);
    sts.out_free    = !out_valid_r || !out_stall;
    priority if (first_r == CH_PLUS)  sts.opk = OPK_ADD;
    else if (first_r == CH_MINUS)     sts.opk = OPK_SUB;
    else if (first_r == CH_STAR)      sts.opk = OPK_MUL;
    else if (first_r == CH_SLASH)     sts.opk = OPK_DIV;
    else                              sts.opk = OPK_BAD;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = $signed(out_value_r);
  assign out_status = out_status_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH)) else $error("stack count beyond depth");
  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == C_EMIT) |=> (cnt_r == '0 && out_valid_r && held_r == ST_OK))
    else $error("emit did not clear stack");
  a_held_code: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= ST_SAT) else $error("held status out of range");
  a_fatal_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK && out_status_r != ST_SAT)
      |-> (out_value_r == 32'd0)) else $error("error result carries a value");

endmodule

// ===== design/rpn_token_stream_calculator.sv =====
// Reverse-Polish calculator fed one ASCII character per transaction, with marks
// for token end and expression end; numbers become signed fixed point with
// FRAC_BITS fraction bits and one result (value, status) leaves per expression.
// A character that does not end a token does not stall the input. Finishing a
// token is done by a sequencer over one shared datapath; * adds a rounding step
// and / uses a bit-serial divider, one quotient bit per cycle. A number being
// pushed is multiplied by ten per power of a positive exponent (stopping early
// once it saturates), or for a negative exponent the power of ten is built up
// (stopping early once it exceeds the value, which becomes zero) and the value
// is divided by it. The operand stack is a single-port memory, so an operator
// reads its operands one after the other.
module rpn_token_stream_calculator #(
  parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH,
  parameter int FRAC_BITS   = rpn_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_ch,
  input  logic               in_token_last,
  input  logic               in_expr_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_value,
  output logic [2:0]         out_status
);
  import rpn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rpn_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_token_last (in_token_last),
    .in_expr_last  (in_expr_last),
    .in_stall      (in_stall),
    .sts           (sts),
    .cmd           (cmd)
  );

  rpn_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_ch      (in_ch),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule

// ===== dv/rpn_token_stream_calculator_test.sv =====
module rpn_token_stream_calculator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rpn_pkg::*;

  localparam int DEPTH = DEF_STACK_DEPTH;
  localparam int FB = DEF_FRAC_BITS;
  localparam int IDLE_LIMIT = 20000;
  localparam longint unsigned MANT_CAP = 64'd100000000000000000;
  localparam longint unsigned MANT_MAX = 64'd999999999999999999;

  typedef enum int {
    P_START, P_SIGN, P_ERR, P_INT, P_FRAC, P_EXPSTART, P_EXPSIGN, P_EXPDIG
  } phase_e;

  typedef struct {
    logic [7:0] ch;
    logic tl;
    logic el;
    bit drain;
  } char_txn_t;

  typedef struct {
    logic [31:0] value;
    logic [2:0] status;
  } calc_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_ch = '0;
  logic in_token_last = 1'b0;
  logic in_expr_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_value;
  logic [2:0] out_status;

  rpn_token_stream_calculator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_ch(in_ch),
    .in_token_last(in_token_last), .in_expr_last(in_expr_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_value(out_value), .out_status(out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  char_txn_t pend_q[$];
  calc_res_t result_q[$];
  int errors = 0;
  int results_seen = 0;

  // calculator shadow state
  logic [31:0] stk[DEPTH];
  int stk_cnt = 0;
  phase_e ph = P_START;
  longint unsigned mant = 0;
  int frac_n = 0;
  int exp_acc = 0;
  bit exp_neg = 0;
  bit val_neg = 0;
  logic [7:0] first_ch = 0;
  int tok_len = 0;
  bit zero_lead = 0;
  logic [2:0] held = ST_OK;

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit fatal_held();
    return held != ST_OK && held != ST_SAT;
  endfunction

  function automatic void flag_fatal(logic [2:0] code);
    if (held == ST_OK || held == ST_SAT) held = code;
  endfunction

  function automatic void flag_sat();
    if (held == ST_OK) held = ST_SAT;
  endfunction

  function automatic logic [63:0] word_mag(logic [31:0] w);
    return w[31] ? {32'd0, -w} : {32'd0, w};
  endfunction

  function automatic logic [31:0] sat_word(bit neg, logic [63:0] mag);
    logic [31:0] m32;
    m32 = mag[31:0];
    if (neg) begin
      if (mag > 64'h80000000) begin
        flag_sat();
        return 32'h80000000;
      end
      return -m32;
    end
    if (mag > 64'h7fffffff) begin
      flag_sat();
      return 32'h7fffffff;
    end
    return m32;
  endfunction

  function automatic logic [31:0] sum_word(longint s);
    if (s < 0) return sat_word(1'b1, -s);
    return sat_word(1'b0, s);
  endfunction

  function automatic logic [31:0] number_to_fixed();
    logic [127:0] lim;
    logic [63:0] a;
    logic [63:0] mag;
    int e;
    bit huge;
    huge = 0;
    if (mant == 0) return '0;
    e = exp_neg ? -exp_acc : exp_acc;
    e -= frac_n;
    lim = {64'd0, mant} << (FB + 1);
    if (e >= 0) begin
      for (int i = 0; i < e && !huge; i++) begin
        if (lim[127:96] != 0) huge = 1;
        else lim = lim * 10;
      end
    end else begin
      for (int i = 0; i < -e && lim != 0; i++) lim = lim / 10;
    end
    if (huge || lim[127:64] != 0) begin
      mag = '1;
    end else begin
      a = lim[63:0];
      mag = (a >> 1) + a[0];
    end
    return sat_word(val_neg, mag);
  endfunction

  function automatic void apply_op(logic [7:0] c);
    logic [31:0] a, b, r;
    logic [63:0] ma, mb, p;
    bit neg;
    if (stk_cnt < 2) begin
      flag_fatal(ST_UNDER);
      return;
    end
    b = stk[stk_cnt-1];
    a = stk[stk_cnt-2];
    ma = word_mag(a);
    mb = word_mag(b);
    neg = a[31] != b[31];
    case (c)
      "+": r = sum_word(longint'($signed(a)) + longint'($signed(b)));
      "-": r = sum_word(longint'($signed(a)) - longint'($signed(b)));
      "*": begin
        p = ma * mb;
        p = (p + ((64'd1 << FB) >> 1)) >> FB;
        r = sat_word(neg, p);
      end
      "/": begin
        if (mb == 0) begin
          flag_sat();
          r = (ma == 0) ? 32'd0 : (a[31] ? 32'h80000000 : 32'h7fffffff);
        end else begin
          p = (ma << (FB + 1)) / mb;
          r = sat_word(neg, (p >> 1) + p[0]);
        end
      end
      default: begin
        flag_fatal(ST_BADOP);
        return;
      end
    endcase
    stk_cnt--;
    stk[stk_cnt-1] = r;
  endfunction

  function automatic void bad_num();
    flag_fatal(ST_BADNUM);
    ph = P_ERR;
  endfunction

  function automatic void exp_first(logic [7:0] c);
    if (c == "0") begin
      zero_lead = 1;
      ph = P_EXPDIG;
    end else if (is_dig(c)) begin
      exp_acc = c - "0";
      ph = P_EXPDIG;
    end else begin
      bad_num();
    end
  endfunction

  function automatic void mant_first(logic [7:0] c, bit allow_exp);
    if (c == "0") begin
      zero_lead = 1;
      ph = P_INT;
    end else if (is_dig(c)) begin
      mant = c - "0";
      ph = P_INT;
    end else if (c == ".") begin
      ph = P_FRAC;
    end else if (allow_exp && (c == "e" || c == "E")) begin
      ph = P_EXPSTART;
    end else if (allow_exp) begin
      ph = P_ERR;
    end else begin
      bad_num();
    end
  endfunction

  function automatic void parse_ch(logic [7:0] c);
    int v;
    case (ph)
      P_START: begin
        if (c == "+" || c == "-") begin
          val_neg = (c == "-");
          ph = P_SIGN;
        end else begin
          mant_first(c, 1'b1);
        end
      end
      P_SIGN: mant_first(c, 1'b0);
      P_INT: begin
        if (zero_lead) begin
          if (c == ".") begin
            zero_lead = 0;
            ph = P_FRAC;
          end else begin
            bad_num();
          end
        end else if (is_dig(c)) begin
          mant = (mant >= MANT_CAP) ? MANT_MAX : mant * 10 + (c - "0");
        end else if (c == ".") begin
          ph = P_FRAC;
        end else if (c == "e" || c == "E") begin
          ph = P_EXPSTART;
        end else begin
          bad_num();
        end
      end
      P_FRAC: begin
        if (is_dig(c)) begin
          if (mant < MANT_CAP && frac_n < 255) begin
            mant = mant * 10 + (c - "0");
            frac_n++;
          end
        end else if (c == "e" || c == "E") begin
          ph = P_EXPSTART;
        end else begin
          bad_num();
        end
      end
      P_EXPSTART: begin
        if (c == "+" || c == "-") begin
          exp_neg = (c == "-");
          ph = P_EXPSIGN;
        end else begin
          exp_first(c);
        end
      end
      P_EXPSIGN: exp_first(c);
      P_EXPDIG: begin
        if (zero_lead) begin
          flag_fatal(ST_BADEXP);
          ph = P_ERR;
        end else if (is_dig(c)) begin
          v = exp_acc * 10 + (c - "0");
          exp_acc = (v > 255) ? 255 : v;
        end else begin
          bad_num();
        end
      end
      default: flag_fatal(ST_BADNUM);
    endcase
  endfunction

  function automatic void end_token();
    if (tok_len == 1 && !is_dig(first_ch)) begin
      if (!fatal_held()) apply_op(first_ch);
    end else if (ph == P_ERR || ph == P_SIGN || ph == P_START) begin
      flag_fatal(ST_BADNUM);
    end else if (!fatal_held()) begin
      if (stk_cnt >= DEPTH) flag_fatal(ST_OVER);
      else begin
        stk[stk_cnt] = number_to_fixed();
        stk_cnt++;
      end
    end
    ph = P_START;
    mant = 0;
    frac_n = 0;
    exp_acc = 0;
    exp_neg = 0;
    val_neg = 0;
    first_ch = 0;
    tok_len = 0;
    zero_lead = 0;
  endfunction

  function automatic void predict_char(char_txn_t t);
    calc_res_t r;
    if (tok_len == 0) first_ch = t.ch;
    parse_ch(t.ch);
    if (tok_len < 2) tok_len++;
    if (!t.tl) return;
    end_token();
    if (!t.el) return;
    r.value = '0;
    if (!fatal_held()) begin
      if (stk_cnt == 0) flag_fatal(ST_UNDER);
      else r.value = stk[stk_cnt-1];
    end
    if (fatal_held()) r.value = '0;
    r.status = held;
    result_q.push_back(r);
    stk_cnt = 0;
    held = ST_OK;
  endfunction

  // stimulus building
  function automatic void add_token(string s, bit el, bit drain = 0);
    char_txn_t t;
    for (int i = 0; i < s.len(); i++) begin
      t.ch = s[i];
      t.tl = (i == s.len() - 1);
      t.el = t.tl ? el : ($urandom_range(0, 19) == 0);
      t.drain = drain && i == 0;
      pend_q.push_back(t);
    end
  endfunction

  function automatic void add_expr(string s);
    string tok;
    tok = "";
    for (int i = 0; i <= s.len(); i++) begin
      if (i == s.len() || s[i] == " ") begin
        add_token(tok, i == s.len());
        tok = "";
      end else begin
        tok = {tok, s.substr(i, i)};
      end
    end
  endfunction

  function automatic string digits(int n, bit lead_nz);
    string s;
    byte d;
    s = "";
    for (int i = 0; i < n; i++) begin
      d = (i == 0 && lead_nz) ? $urandom_range(1, 9) : $urandom_range(0, 9);
      s = {s, string'(8'("0") + d)};
    end
    return s;
  endfunction

  function automatic string rand_number();
    string s;
    int k;
    s = "";
    k = $urandom_range(0, 2);
    if (k == 1) s = "-";
    else if (k == 2) s = "+";
    k = $urandom_range(0, 9);
    if (k == 0) s = {s, "0"};
    else if (k == 1) s = {s, digits($urandom_range(17, 22), 1)};
    else if (k > 3) s = {s, digits($urandom_range(1, 5), 1)};
    if ($urandom_range(0, 2) == 0 || s.len() == 0 || s == "-" || s == "+") begin
      s = {s, "."};
      if ($urandom_range(0, 15) == 0) s = {s, digits($urandom_range(15, 30), 0)};
      else s = {s, digits($urandom_range(1, 5), 0)};
    end
    if ($urandom_range(0, 3) == 0) begin
      s = {s, $urandom_range(0, 1) ? "e" : "E"};
      k = $urandom_range(0, 2);
      if (k == 1) s = {s, "-"};
      else if (k == 2) s = {s, "+"};
      k = $urandom_range(0, 7);
      if (k == 0) s = {s, "0"};
      else if (k == 1) s = {s, digits(3, 1)};
      else s = {s, digits($urandom_range(1, 2), 1)};
    end
    return s;
  endfunction

  function automatic string rand_noise();
    string s;
    s = "";
    for (int i = $urandom_range(1, 4); i > 0; i--)
      s = {s, string'(8'($urandom_range(0, 255)))};
    return s;
  endfunction

  function automatic string rand_op();
    case ($urandom_range(0, 3))
      0: return "+";
      1: return "-";
      2: return "*";
      default: return "/";
    endcase
  endfunction

  function automatic void add_rand_expr(bit drain);
    int kind, d, n;
    kind = $urandom_range(0, 9);
    d = 0;
    if (kind < 8) begin
      n = $urandom_range(1, 6);
      while (n > 0 || d > 1) begin
        if (d < 2 || (n > 0 && d < DEPTH - 1 && $urandom_range(0, 1))) begin
          add_token(rand_number(), 0, drain);
          d++;
          n--;
        end else begin
          add_token(rand_op(), 0, drain);
          d--;
        end
        drain = 0;
      end
      add_token(rand_op(), 0);
      pend_q.pop_back();
      pend_q[$].el = 1;
      pend_q[$].tl = 1;
    end else if (kind == 8) begin
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 3))
          0: add_token(rand_noise(), i == n - 1, drain && i == 0);
          1: add_token(rand_op(), i == n - 1, drain && i == 0);
          2: add_token(string'(8'($urandom_range(0, 255))), i == n - 1, drain && i == 0);
          default: add_token(rand_number(), i == n - 1, drain && i == 0);
        endcase
      end
    end else begin
      n = $urandom_range(DEPTH - 1, DEPTH + 2);
      for (int i = 0; i < n; i++) add_token(digits(1, 0), i == n - 1, drain && i == 0);
    end
  endfunction

  // driver
  char_txn_t cur;
  int gap = 0;
  bit burst = 0;
  bit drv_free;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      drv_free = !in_valid || !in_stall;
      if (in_valid && !in_stall) predict_char(cur);
      if (drv_free) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (pend_q.size() > 0 && !(pend_q[0].drain && result_q.size() > 0)) begin
          cur = pend_q.pop_front();
          in_ch <= cur.ch;
          in_token_last <= cur.tl;
          in_expr_last <= cur.el;
          in_valid <= 1'b1;
          if ($urandom_range(0, 19) == 0) burst = !burst;
          gap = burst ? 0 : $urandom_range(0, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int hold_left = 0;
  bit mon_burst = 0;
  calc_res_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (result_q.size() == 0) begin
          $error("unexpected result transaction: value %0d status %0d", out_value, out_status);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (out_value !== want.value) begin
            $error("value mismatch: expected %0d, got %0d", $signed(want.value), out_value);
            errors++;
          end
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
        end
        if ($urandom_range(0, 9) == 0) mon_burst = !mon_burst;
        hold_left = (results_seen == 4) ? 3000 : (mon_burst ? 0 : $urandom_range(0, 11));
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    add_expr("0");
    add_expr("-0.5 +.25e1 +");
    add_expr("7 3 - 1.5 -2 * *");
    add_expr("1 3 /");
    add_expr("1 0 / -5 0 / 0 0 /");
    add_expr("32767 32767 *");
    add_expr("-40000 40000 -");
    add_expr("1e5 1e-6 1E+2 . 1e");
    add_expr("00");
    add_expr("1e05");
    add_expr("+");
    add_expr("1 2 x");
    add_expr("-");
    add_expr("5 6");
    for (int i = 0; i < DEPTH + 1; i++) add_token("9", i == DEPTH);
    while (pend_q.size() < 500) add_rand_expr(pend_q.size() > 250 && pend_q.size() < 270);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (pend_q.size() > 0 || in_valid || result_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
